[hw/rtl/upd_pkg.sv]
// upd_pkg: shared types, character codes and helper functions for the url percent decoder
// no dependencies; used by upd_decode, upd_burst and url_percent_decoder

package upd_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PATH = 2'd0;
  localparam mode_t MODE_COMP = 2'd1;
  localparam mode_t MODE_USER = 2'd2;

  // escape progress: nothing pending, '%' seen, '%' and first digit seen
  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ALL1  = 8'hFF;

  localparam int unsigned BURST_MAX = 3;

  // one processed request: up to three bytes, first one in bytes[0]
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [BURST_MAX-1:0][7:0]  bytes;
    logic                       eos;
  } dec_t;

  // hex digit value, bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

  // decoded values that must stay escaped in the current mode
  function automatic logic refused(input mode_t m, input logic [7:0] v);
    logic r;
    r = 1'b0;
    if (m == MODE_COMP) begin
      r = 1'b0;
    end else if (v == CH_NUL) begin
      r = 1'b1;
    end else if (m == MODE_PATH) begin
      case (v)
        // # $ & + , / : ; = ? @
        8'h23, 8'h24, 8'h26, 8'h2B, 8'h2C, 8'h2F,
        8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40: r = 1'b1;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

[hw/rtl/upd_in_if.sv]
// upd_in_if: request channel carrying raw url bytes into the decoder
// no dependencies

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

[hw/rtl/upd_out_if.sv]
// upd_out_if: result channel carrying decoded bytes out of the decoder
// no dependencies

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last_of_item;
  logic       out_end_of_string;

  modport source (output valid, output out_byte, output out_last_of_item,
                  output out_end_of_string, input ready);
  modport sink (input valid, input out_byte, input out_last_of_item,
                input out_end_of_string, output ready);
endinterface

[hw/rtl/upd_decode.sv]
// upd_decode: combinational escape decoding for one registered request
// depends on upd_pkg

module upd_decode (
  input  upd_pkg::mode_t mode_i,
  input  upd_pkg::esc_t  esc_i,
  input  logic [7:0]     fd_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output upd_pkg::dec_t  res_o,
  output upd_pkg::esc_t  esc_o,
  output logic [7:0]     fd_o
);

  logic [4:0] hi;
  logic [4:0] lo;
  logic [7:0] val;
  logic       bad;

  assign hi  = upd_pkg::hex_val(fd_i);
  assign lo  = upd_pkg::hex_val(byte_i);
  assign val = {hi[3:0], lo[3:0]};
  assign bad = hi[4] | lo[4] | (val == upd_pkg::CH_ALL1) | upd_pkg::refused(mode_i, val);

  always_comb begin
    res_o.cnt   = 2'd1;
    res_o.bytes = '0;
    res_o.eos   = last_i;
    esc_o       = upd_pkg::ESC_IDLE;
    fd_o        = fd_i;
    case (esc_i)
      upd_pkg::ESC_PCT: begin
        if (!last_i) begin
          res_o.cnt = 2'd0;
          fd_o      = byte_i;
          esc_o     = upd_pkg::ESC_DIGIT;
        end else begin
          // short escape at end of string, flush raw
          res_o.cnt      = 2'd2;
          res_o.bytes[0] = upd_pkg::CH_PCT;
          res_o.bytes[1] = byte_i;
        end
      end
      upd_pkg::ESC_DIGIT: begin
        if (bad) begin
          res_o.cnt      = 2'd3;
          res_o.bytes[0] = upd_pkg::CH_PCT;
          res_o.bytes[1] = fd_i;
          res_o.bytes[2] = byte_i;
        end else begin
          res_o.bytes[0] = val;
        end
      end
      default: begin
        if (byte_i == upd_pkg::CH_PCT && !last_i) begin
          res_o.cnt = 2'd0;
          esc_o     = upd_pkg::ESC_PCT;
        end else if (byte_i == upd_pkg::CH_PLUS && mode_i == upd_pkg::MODE_COMP) begin
          res_o.bytes[0] = upd_pkg::CH_SPACE;
        end else begin
          res_o.bytes[0] = byte_i;
        end
      end
    endcase
  end

endmodule

[hw/rtl/upd_burst.sv]
// upd_burst: result register holding up to three bytes, drained one per cycle while the output is ready
// depends on upd_pkg

module upd_burst (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_i,
  input  upd_pkg::dec_t res_i,
  input  logic          pop_i,
  output logic          free_o,
  output logic          valid_o,
  output logic [7:0]    byte_o,
  output logic          last_item_o,
  output logic          eos_o
);

  logic [1:0]                         rem_r;
  logic [upd_pkg::BURST_MAX-1:0][7:0] bytes_r;
  logic                               eos_r;

  assign free_o      = (rem_r == 2'd0) || (rem_r == 2'd1 && pop_i);
  assign valid_o     = (rem_r != 2'd0);
  assign byte_o      = bytes_r[0];
  assign last_item_o = (rem_r == 2'd1);
  assign eos_o       = (rem_r == 2'd1) && eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (load_i) begin
      rem_r <= res_i.cnt;
    end else if (pop_i) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  // payload needs no reset, shift toward slot 0 on each pop
  always_ff @(posedge clk) begin
    if (load_i) begin
      bytes_r <= res_i.bytes;
      eos_r   <= res_i.eos;
    end else if (pop_i) begin
      bytes_r[0] <= bytes_r[1];
      bytes_r[1] <= bytes_r[2];
    end
  end

endmodule

[hw/rtl/url_percent_decoder.sv]
// url_percent_decoder: streaming url percent decoder, one raw byte per request
// an accepted request is held in the stage-1 register, then decoded into the result register
// throughput: one request per cycle while the result register is free; a multi-byte raw escape
// holds the input back until its bytes have drained through the single-byte result port
// reset (rst_n low, synchronous): no escape pending, mode = path, channels empty
// depends on upd_pkg, upd_in_if, upd_out_if, upd_decode, upd_burst

module url_percent_decoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_wdata,
  upd_in_if.sink         in_ch,
  upd_out_if.source      out_ch
);

  upd_pkg::mode_t mode_r;
  upd_pkg::esc_t  esc_r;
  upd_pkg::esc_t  esc_nxt;
  logic [7:0]     fd_r;
  logic [7:0]     fd_nxt;

  logic           s1_valid_r;
  logic [7:0]     s1_byte_r;
  logic           s1_last_r;

  upd_pkg::dec_t  dec;
  logic           burst_free;
  logic           s1_fire;
  logic           in_fire;
  logic           pop;

  assign s1_fire     = s1_valid_r && burst_free;
  assign in_ch.ready = !s1_valid_r || burst_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= upd_pkg::MODE_PATH;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      esc_r      <= upd_pkg::ESC_IDLE;
      fd_r       <= 8'h00;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        esc_r <= esc_nxt;
        fd_r  <= fd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.in_byte;
      s1_last_r <= in_ch.in_last;
    end
  end

  upd_decode u_decode (
    .mode_i (mode_r),
    .esc_i  (esc_r),
    .fd_i   (fd_r),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .res_o  (dec),
    .esc_o  (esc_nxt),
    .fd_o   (fd_nxt)
  );

  upd_burst u_burst (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (s1_fire),
    .res_i       (dec),
    .pop_i       (pop),
    .free_o      (burst_free),
    .valid_o     (out_ch.valid),
    .byte_o      (out_ch.out_byte),
    .last_item_o (out_ch.out_last_of_item),
    .eos_o       (out_ch.out_end_of_string)
  );

  // end of string always returns to no escape pending
  a_last_clears_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (esc_r == upd_pkg::ESC_IDLE))
    else $error("escape state not cleared after last byte");

  // a request with no result only happens mid-string
  a_empty_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && dec.cnt == 2'd0) |-> !s1_last_r)
    else $error("last byte produced no result");

  // last byte of the string shows up with end flag on its final result
  a_last_flags_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (out_ch.valid &&
      (out_ch.out_end_of_string == out_ch.out_last_of_item)))
    else $error("end of string flag missing");

  // with no escape pending, a request yields at most one byte
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && esc_r == upd_pkg::ESC_IDLE) |-> (dec.cnt == 2'd0 || dec.cnt == 2'd1))
    else $error("idle state produced more than one byte");

endmodule
